@@ rtl/clnib_pkg.sv @@
// Shared types and constants for the character LCD 4-bit bus sequencer.
// Holds the transaction payload structs, the configuration struct and codes.
// No dependencies.
`default_nettype none

package clnib_pkg;

    // Default width of the wait counter.
    localparam int CNT_BITS_DEF = 16;

    // Request codes carried in the func field.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_PON   = 2'd2;
    localparam logic [1:0] FUNC_POFF  = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] REG_PULSE      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAP        = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLEAR      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_WAKE       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WAKE_FINAL = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_START      = 3'd6;

    // Program step markers: wake nibbles, init bytes, host byte.
    localparam logic [3:0] STEP_WAKE_LAST  = 4'd3;
    localparam logic [3:0] STEP_INIT_FIRST = 4'd4;
    localparam logic [3:0] STEP_INIT_LAST  = 4'd8;
    localparam logic [3:0] STEP_HOST       = 4'd9;

    // Command byte that needs the extra clear wait.
    localparam logic [7:0] CMD_CLEAR = 8'h01;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] byte_value;
        logic       is_data;
    } t_in_item;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] data_nibble;
        logic       enable_strobe;
        logic       boost_on;
        logic       busy_res;
        logic       rejected;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  pulse_ticks;
        logic [9:0]  nibble_gap_ticks;
        logic [15:0] clear_wait_ticks;
        logic [15:0] wake_nibble_wait_ticks;
        logic [15:0] wake_final_wait_ticks;
        logic [15:0] boost_settle_ticks;
        logic [15:0] controller_start_ticks;
    } t_cfg;

    // Power-on initialization command bytes.
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h28;
            3'd1:    b = 8'h08;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h06;
            3'd4:    b = 8'h0c;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/clnib_seq.sv @@
// Bus sequencer state and per-transaction step logic.
// Depends on clnib_pkg for payload, configuration and step constants.
`default_nettype none

module clnib_seq #(
    parameter int COUNT_BITS = clnib_pkg::CNT_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  clnib_pkg::t_in_item  i_item,
    input  clnib_pkg::t_cfg      i_cfg,
    output clnib_pkg::t_out_item o_result
);
    import clnib_pkg::*;

    localparam int unsigned CNT_MAX = (1 << COUNT_BITS) - 1;

    typedef enum logic [2:0] {
        PH_IDLE, PH_SETTLE, PH_START, PH_NIB_EN, PH_NIB_GAP, PH_CLEAR
    } t_phase;

    typedef struct packed {
        t_phase                phase;
        logic [COUNT_BITS-1:0] wait_cnt;
        logic [7:0]            held_byte;
        logic                  held_rs;
        logic                  low_half_next;
        logic [3:0]            program_step;
        logic [5:0]            pins;
    } t_st;

    t_st  r_st, n_st;
    logic r_powered, n_powered;
    logic n_rej;

    // Saturate a 16-bit tick count to the counter width.
    function automatic logic [COUNT_BITS-1:0] clip(input logic [15:0] v);
        logic [COUNT_BITS-1:0] res;
        if (32'(v) > CNT_MAX) begin
            res = COUNT_BITS'(CNT_MAX);
        end else begin
            res = COUNT_BITS'(v);
        end
        return res;
    endfunction

    function automatic logic [COUNT_BITS-1:0] at_least_one(input logic [15:0] v);
        logic [COUNT_BITS-1:0] res;
        if (v == 16'd0) begin
            res = COUNT_BITS'(1);
        end else begin
            res = clip(v);
        end
        return res;
    endfunction

    // Drive RS and a nibble with enable high, then hold for the pulse time.
    function automatic t_st emit(input t_st s, input logic rs, input logic [3:0] nib,
                                 input t_cfg c);
        t_st r;
        r          = s;
        r.pins     = {1'b1, nib, rs};
        r.phase    = PH_NIB_EN;
        r.wait_cnt = at_least_one({8'd0, c.pulse_ticks});
        return r;
    endfunction

    function automatic t_st begin_byte(input t_st s, input logic [7:0] b, input logic rs,
                                       input t_cfg c);
        t_st r;
        r               = s;
        r.held_byte     = b;
        r.held_rs       = rs;
        r.low_half_next = 1'b0;
        return emit(r, rs, b[7:4], c);
    endfunction

    // End of a byte: go on with the init program or drop to idle.
    function automatic t_st finish_byte(input t_st s, input t_cfg c);
        t_st        r;
        logic [3:0] nstep;
        r     = s;
        nstep = s.program_step + 4'd1;
        if (s.program_step >= STEP_INIT_FIRST && s.program_step < STEP_INIT_LAST) begin
            r.program_step = nstep;
            r = begin_byte(r, init_byte(3'(nstep - STEP_INIT_FIRST)), 1'b0, c);
        end else begin
            r.phase    = PH_IDLE;
            r.wait_cnt = '0;
        end
        return r;
    endfunction

    // One sequencer action taken when the current wait has run out.
    function automatic t_st advance(input t_st s, input t_cfg c);
        t_st        r;
        logic [3:0] nstep;
        r     = s;
        nstep = s.program_step + 4'd1;
        unique case (s.phase)
            PH_SETTLE: begin
                r.phase    = PH_START;
                r.wait_cnt = clip(c.controller_start_ticks);
            end
            PH_START: begin
                r.program_step = 4'd0;
                r.held_rs      = 1'b0;
                r = emit(r, 1'b0, 4'd3, c);
            end
            PH_NIB_EN: begin
                r.pins[5] = 1'b0;
                r.phase   = PH_NIB_GAP;
                if (s.program_step < STEP_WAKE_LAST) begin
                    r.wait_cnt = clip(c.wake_nibble_wait_ticks);
                end else if (s.program_step == STEP_WAKE_LAST) begin
                    r.wait_cnt = clip(c.wake_final_wait_ticks);
                end else begin
                    r.wait_cnt = at_least_one({6'd0, c.nibble_gap_ticks});
                end
            end
            PH_NIB_GAP: begin
                if (s.program_step <= STEP_WAKE_LAST) begin
                    r.program_step = nstep;
                    if (nstep < STEP_WAKE_LAST) begin
                        r = emit(r, 1'b0, 4'd3, c);
                    end else if (nstep == STEP_WAKE_LAST) begin
                        r = emit(r, 1'b0, 4'd2, c);
                    end else begin
                        r = begin_byte(r, init_byte(3'd0), 1'b0, c);
                    end
                end else if (!s.low_half_next) begin
                    r.low_half_next = 1'b1;
                    r = emit(r, s.held_rs, s.held_byte[3:0], c);
                end else if (!s.held_rs && s.held_byte == CMD_CLEAR) begin
                    r.phase    = PH_CLEAR;
                    r.wait_cnt = clip(c.clear_wait_ticks);
                end else begin
                    r = finish_byte(r, c);
                end
            end
            PH_CLEAR: begin
                r = finish_byte(r, c);
            end
            default: begin
                r.phase    = PH_IDLE;
                r.wait_cnt = '0;
            end
        endcase
        return r;
    endfunction

    // Step logic. Zero-length waits chain at most two actions in one tick:
    // an action that starts a nibble always loads a nonzero pulse time.
    always_comb begin
        t_st s0, s1;
        logic busy;
        s0        = r_st;
        n_powered = r_powered;
        n_rej     = 1'b0;
        busy      = (r_st.phase != PH_IDLE);
        s1        = s0;
        case (i_item.func)
            FUNC_TICK: begin
                if (busy) begin
                    if (s0.wait_cnt != '0) begin
                        s0.wait_cnt = s0.wait_cnt - COUNT_BITS'(1);
                    end
                    s1 = s0;
                    if (s0.phase != PH_IDLE && s0.wait_cnt == '0) begin
                        s1 = advance(s0, i_cfg);
                    end
                    if (s1.phase != PH_IDLE && s1.wait_cnt == '0) begin
                        s1 = advance(s1, i_cfg);
                    end
                end
            end
            FUNC_WRITE: begin
                if (busy) begin
                    n_rej = 1'b1;
                end else begin
                    s0.program_step = STEP_HOST;
                    s1 = begin_byte(s0, i_item.byte_value, i_item.is_data, i_cfg);
                end
            end
            FUNC_PON: begin
                if (busy || r_powered) begin
                    n_rej = 1'b1;
                end else begin
                    n_powered   = 1'b1;
                    s1.phase    = PH_SETTLE;
                    s1.wait_cnt = clip(i_cfg.boost_settle_ticks);
                end
            end
            default: begin
                if (busy || !r_powered) begin
                    n_rej = 1'b1;
                end else begin
                    n_powered = 1'b0;
                end
            end
        endcase
        n_st = s1;
    end

    // Result item for the transaction being accepted.
    always_comb begin
        o_result.reg_select    = n_st.pins[0];
        o_result.data_nibble   = n_st.pins[4:1];
        o_result.enable_strobe = n_st.pins[5];
        o_result.boost_on      = n_powered;
        o_result.busy_res      = (n_st.phase != PH_IDLE);
        o_result.rejected      = n_rej;
    end

    // Sequencer state, updated once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase         <= PH_IDLE;
            r_st.wait_cnt      <= '0;
            r_st.held_byte     <= 8'd0;
            r_st.held_rs       <= 1'b0;
            r_st.low_half_next <= 1'b0;
            r_st.program_step  <= 4'd0;
            r_st.pins          <= 6'd0;
            r_powered          <= 1'b0;
        end else if (i_accept) begin
            r_st      <= n_st;
            r_powered <= n_powered;
        end
    end

endmodule

`default_nettype wire

@@ rtl/clnib_outbuf.sv @@
// Two-entry output buffer: a result register plus a skid register.
// Depends on clnib_pkg for the result payload type.
`default_nettype none

module clnib_outbuf (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  clnib_pkg::t_out_item i_data,
    output logic                 o_space,
    output logic                 o_valid,
    input  wire                  i_ready,
    output clnib_pkg::t_out_item o_data
);
    import clnib_pkg::*;

    t_out_item r_main, r_skid;
    logic      r_main_v, r_skid_v;
    logic      pop;

    assign pop     = r_main_v && i_ready;
    assign o_valid = r_main_v;
    assign o_data  = r_main;
    assign o_space = !r_skid_v;

    // Valid flags: the skid fills only when the main register stays occupied.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop) begin
            r_main_v <= r_skid_v || i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_main_v <= 1'b1;
            r_skid_v <= r_main_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_v ? r_skid : i_data;
        end else if (i_push) begin
            if (r_main_v) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/char_lcd_nibble_interface_core.sv @@
// Top level of the character LCD 4-bit bus sequencer.
// Depends on clnib_pkg, clnib_seq and clnib_outbuf.
//
// Channel   Direction  Handshake                  Payload
// in        to core    i_in_valid / o_in_ready    i_in  (t_in_item)
// out       from core  o_out_valid / i_out_ready  o_out (t_out_item)
// cfg       to core    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Every transaction is worked in the cycle it is accepted; its result is
// registered and shown on out. One transaction per cycle is sustained while
// results are taken. A two-entry output buffer lets input take one more
// transaction under an output stall; o_in_ready then drops until a result
// is taken. Reset is synchronous, active low, and restores register defaults.
`default_nettype none

module char_lcd_nibble_interface_core #(
    parameter int COUNT_BITS = clnib_pkg::CNT_BITS_DEF
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_in_valid,
    output logic                                     o_in_ready,
    input  clnib_pkg::t_in_item                      i_in,
    output logic                                     o_out_valid,
    input  wire                                      i_out_ready,
    output clnib_pkg::t_out_item                     o_out,
    input  wire                                      i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire [clnib_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  wire [clnib_pkg::CFG_DATA_BITS-1:0]       i_cfg_data
);
    import clnib_pkg::*;

    t_cfg      r_cfg;
    t_out_item result;
    logic      accept;
    logic      space;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && space;
    assign o_in_ready  = space;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_ticks            <= 8'd1;
            r_cfg.nibble_gap_ticks       <= 10'd50;
            r_cfg.clear_wait_ticks       <= 16'd2000;
            r_cfg.wake_nibble_wait_ticks <= 16'd5000;
            r_cfg.wake_final_wait_ticks  <= 16'd150;
            r_cfg.boost_settle_ticks     <= 16'd10000;
            r_cfg.controller_start_ticks <= 16'd50000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PULSE:      r_cfg.pulse_ticks            <= i_cfg_data[7:0];
                REG_GAP:        r_cfg.nibble_gap_ticks       <= i_cfg_data[9:0];
                REG_CLEAR:      r_cfg.clear_wait_ticks       <= i_cfg_data;
                REG_WAKE:       r_cfg.wake_nibble_wait_ticks <= i_cfg_data;
                REG_WAKE_FINAL: r_cfg.wake_final_wait_ticks  <= i_cfg_data;
                REG_SETTLE:     r_cfg.boost_settle_ticks     <= i_cfg_data;
                REG_START:      r_cfg.controller_start_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    clnib_seq #(
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    clnib_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out)
    );

endmodule

`default_nettype wire

@@ rtl/clnib_checker.sv @@
// Port-level checks for the character LCD 4-bit bus sequencer, bound to its top.
// Depends on clnib_pkg and char_lcd_nibble_interface_core.
`default_nettype none

module clnib_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_ready,
    input clnib_pkg::t_in_item  i_in,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input clnib_pkg::t_out_item o_out
);
    import clnib_pkg::*;

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Reset empties the output buffer.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Input is held back only while a result is waiting.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no pending result");

    // Enable is high only inside a running sequence.
    a_enable_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.enable_strobe |-> o_out.busy_res)
        else $error("enable high while idle");

endmodule

bind char_lcd_nibble_interface_core clnib_checker u_clnib_checker (.*);

`default_nettype wire

@@ test/tb_char_lcd_nibble_interface_core.sv @@
// Self-checking testbench for the character LCD 4-bit bus sequencer core.
// Predicts every result from its own model of the sequencer and compares it field by field.
// Depends on clnib_pkg and char_lcd_nibble_interface_core.
`default_nettype none

module tb_char_lcd_nibble_interface_core;
    timeunit 1ns;
    timeprecision 1ps;

    import clnib_pkg::*;

    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int LONG_HOLD    = 60;

    // Index that maps to no register; writes to it must be ignored.
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    // Nibbles of the wake sequence and the bytes of the power-on program.
    localparam logic [3:0] WAKE_NIB  = 4'h3;
    localparam logic [3:0] MODE4_NIB = 4'h2;
    localparam logic [4:0][7:0] BOOT_CMDS = {8'h0c, 8'h06, CMD_CLEAR, 8'h08, 8'h28};

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SETTLE,
        SEQ_START,
        SEQ_STROBE,
        SEQ_GAP,
        SEQ_CLEAR
    } seq_phase_e;

    typedef logic [6:0][15:0] reg_image_t;

    // Clock, reset and the signals on the block's ports.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in_item in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_item out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // Requests waiting to be offered, and bus levels predicted for accepted ones.
    t_in_item pending_q[$];
    t_out_item bus_levels_q[$];

    // Predicted sequencer state and configuration.
    t_cfg lcd_cfg;
    logic m_powered;
    seq_phase_e m_phase;
    int m_wait;
    logic [7:0] m_byte;
    logic m_rs;
    logic m_low_half;
    logic [3:0] m_step;
    logic [5:0] m_pins;
    logic m_effect;

    int mismatches = 0;
    int useful_items = 0;
    int results_seen = 0;
    int unsigned cycle_count = 0;
    int drv_idle = 0;
    int drv_calm = 0;
    int mon_stall = 0;
    int mon_calm = 0;
    logic long_hold_done = 1'b0;
    t_out_item want;

    char_lcd_nibble_interface_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Sequencer model.

    function automatic void lcd_reset();
        lcd_cfg.pulse_ticks = 8'd1;
        lcd_cfg.nibble_gap_ticks = 10'd50;
        lcd_cfg.clear_wait_ticks = 16'd2000;
        lcd_cfg.wake_nibble_wait_ticks = 16'd5000;
        lcd_cfg.wake_final_wait_ticks = 16'd150;
        lcd_cfg.boost_settle_ticks = 16'd10000;
        lcd_cfg.controller_start_ticks = 16'd50000;
        m_powered = 1'b0;
        m_phase = SEQ_IDLE;
        m_wait = 0;
        m_byte = '0;
        m_rs = 1'b0;
        m_low_half = 1'b0;
        m_step = '0;
        m_pins = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_PULSE:      lcd_cfg.pulse_ticks = data[7:0];
            REG_GAP:        lcd_cfg.nibble_gap_ticks = data[9:0];
            REG_CLEAR:      lcd_cfg.clear_wait_ticks = data;
            REG_WAKE:       lcd_cfg.wake_nibble_wait_ticks = data;
            REG_WAKE_FINAL: lcd_cfg.wake_final_wait_ticks = data;
            REG_SETTLE:     lcd_cfg.boost_settle_ticks = data;
            REG_START:      lcd_cfg.controller_start_ticks = data;
            default: ;
        endcase
    endfunction

    // Put one nibble on the bus with enable raised; a zero pulse length counts as one.
    function automatic void strobe_nibble(input logic rs, input logic [3:0] nib);
        m_pins = {1'b1, nib, rs};
        m_phase = SEQ_STROBE;
        m_wait = int'(lcd_cfg.pulse_ticks);
        if (m_wait == 0) m_wait = 1;
    endfunction

    function automatic void start_byte(input logic [7:0] b, input logic rs);
        m_byte = b;
        m_rs = rs;
        m_low_half = 1'b0;
        strobe_nibble(rs, b[7:4]);
    endfunction

    // After a byte, either move on to the next power-on command or go idle.
    function automatic void end_byte();
        if (m_step >= STEP_INIT_FIRST && m_step < STEP_INIT_LAST) begin
            m_step = m_step + 4'd1;
            start_byte(BOOT_CMDS[3'(m_step - STEP_INIT_FIRST)], 1'b0);
        end else begin
            m_phase = SEQ_IDLE;
            m_wait = 0;
        end
    endfunction

    // Action taken when the current wait has run out.
    function automatic void advance_seq();
        case (m_phase)
            SEQ_SETTLE: begin
                m_phase = SEQ_START;
                m_wait = int'(lcd_cfg.controller_start_ticks);
            end
            SEQ_START: begin
                m_step = '0;
                m_rs = 1'b0;
                strobe_nibble(1'b0, WAKE_NIB);
            end
            SEQ_STROBE: begin
                m_pins[5] = 1'b0;
                m_phase = SEQ_GAP;
                if (m_step < STEP_WAKE_LAST) begin
                    m_wait = int'(lcd_cfg.wake_nibble_wait_ticks);
                end else if (m_step == STEP_WAKE_LAST) begin
                    m_wait = int'(lcd_cfg.wake_final_wait_ticks);
                end else begin
                    m_wait = int'(lcd_cfg.nibble_gap_ticks);
                    if (m_wait == 0) m_wait = 1;
                end
            end
            SEQ_GAP: begin
                if (m_step <= STEP_WAKE_LAST) begin
                    m_step = m_step + 4'd1;
                    if (m_step < STEP_WAKE_LAST) strobe_nibble(1'b0, WAKE_NIB);
                    else if (m_step == STEP_WAKE_LAST) strobe_nibble(1'b0, MODE4_NIB);
                    else start_byte(BOOT_CMDS[0], 1'b0);
                end else if (!m_low_half) begin
                    m_low_half = 1'b1;
                    strobe_nibble(m_rs, m_byte[3:0]);
                end else if (!m_rs && m_byte == CMD_CLEAR) begin
                    m_phase = SEQ_CLEAR;
                    m_wait = int'(lcd_cfg.clear_wait_ticks);
                end else begin
                    end_byte();
                end
            end
            SEQ_CLEAR: end_byte();
            default: begin
                m_phase = SEQ_IDLE;
                m_wait = 0;
            end
        endcase
    endfunction

    // Apply one transaction to the model and return the bus levels it leaves.
    function automatic t_out_item lcd_step(input t_in_item it);
        t_out_item r;
        logic busy;
        logic rej;
        busy = (m_phase != SEQ_IDLE);
        rej = 1'b0;
        case (it.func)
            FUNC_TICK: begin
                if (busy) begin
                    if (m_wait > 0) m_wait--;
                    while (m_phase != SEQ_IDLE && m_wait == 0) advance_seq();
                end
            end
            FUNC_WRITE: begin
                if (busy) begin
                    rej = 1'b1;
                end else begin
                    m_step = STEP_HOST;
                    start_byte(it.byte_value, it.is_data);
                end
            end
            FUNC_PON: begin
                if (busy || m_powered) begin
                    rej = 1'b1;
                end else begin
                    m_powered = 1'b1;
                    m_phase = SEQ_SETTLE;
                    m_wait = int'(lcd_cfg.boost_settle_ticks);
                end
            end
            default: begin
                if (busy || !m_powered) rej = 1'b1;
                else m_powered = 1'b0;
            end
        endcase
        m_effect = (it.func == FUNC_TICK) ? busy : !rej;
        r.reg_select = m_pins[0];
        r.data_nibble = m_pins[4:1];
        r.enable_strobe = m_pins[5];
        r.boost_on = m_powered;
        r.busy_res = (m_phase != SEQ_IDLE);
        r.rejected = rej;
        return r;
    endfunction

    // Length of the next pause: mostly none, some short, a few long, with calm stretches.
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 3) begin
            calm = $urandom_range(50, 200);
            return 0;
        end
        if (r < 700) return 0;
        if (r < 960) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void report_field(input string name, input logic [7:0] want_v,
                                         input logic [7:0] got_v);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    endfunction

    function automatic void queue_item(input logic [1:0] f, input logic [7:0] b,
                                       input logic d);
        t_in_item it;
        it.func = f;
        it.byte_value = b;
        it.is_data = d;
        pending_q.push_back(it);
    endfunction

    // Request driver: offers queued transactions and updates the model on acceptance.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                bus_levels_q.push_back(lcd_step(in_item));
                if (m_effect) useful_items++;
                void'(pending_q.pop_front());
                drv_idle = pick_idle(drv_calm);
            end
            if (in_valid && !in_ready) begin
                in_valid <= 1'b1;
            end else if (drv_idle > 0) begin
                drv_idle--;
                in_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                in_valid <= 1'b1;
                in_item <= pending_q[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted result and stalls the output at random.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                results_seen++;
                if (bus_levels_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result with none expected, expected none, got %h",
                             $time, out_item);
                end else begin
                    want = bus_levels_q.pop_front();
                    if (out_item.reg_select !== want.reg_select)
                        report_field("reg_select", 8'(want.reg_select),
                                     8'(out_item.reg_select));
                    if (out_item.data_nibble !== want.data_nibble)
                        report_field("data_nibble", 8'(want.data_nibble),
                                     8'(out_item.data_nibble));
                    if (out_item.enable_strobe !== want.enable_strobe)
                        report_field("enable_strobe", 8'(want.enable_strobe),
                                     8'(out_item.enable_strobe));
                    if (out_item.boost_on !== want.boost_on)
                        report_field("boost_on", 8'(want.boost_on), 8'(out_item.boost_on));
                    if (out_item.busy_res !== want.busy_res)
                        report_field("busy_res", 8'(want.busy_res), 8'(out_item.busy_res));
                    if (out_item.rejected !== want.rejected)
                        report_field("rejected", 8'(want.rejected), 8'(out_item.rejected));
                end
            end
            // One long hold while requests keep coming, so the block has to back up.
            if (!long_hold_done && results_seen > 300 && pending_q.size() > 4) begin
                long_hold_done = 1'b1;
                mon_stall = LONG_HOLD;
            end
            if (mon_stall > 0) begin
                mon_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                mon_stall = pick_idle(mon_calm);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Write all seven registers, optionally followed by a write to an unused index.
    task automatic program_regs(input reg_image_t img, input logic stray);
        logic [CFG_IDX_BITS-1:0] idx;
        @(posedge clk);
        for (idx = REG_PULSE; idx <= REG_START; idx++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= img[idx];
            do @(posedge clk); while (!cfg_ready);
            apply_reg(idx, img[idx]);
        end
        if (stray) begin
            cfg_index <= REG_UNUSED;
            cfg_data <= '1;
            do @(posedge clk); while (!cfg_ready);
            apply_reg(REG_UNUSED, '1);
        end
        cfg_valid <= 1'b0;
    endtask

    // Wait until every request is accepted and every result has been checked.
    task automatic drain();
        @(negedge clk);
        while (pending_q.size() != 0 || bus_levels_q.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Feed ticks, with the odd stray request while busy, until the sequencer is idle.
    task automatic run_to_idle();
        int n;
        @(negedge clk);
        while (pending_q.size() != 0) @(negedge clk);
        while (m_phase != SEQ_IDLE) begin
            if ($urandom_range(0, 5) == 0)
                queue_item(2'($urandom_range(FUNC_WRITE, FUNC_POFF)), 8'($urandom),
                           1'($urandom));
            n = (m_wait > 1) ? m_wait : 1;
            if (n > 300) n = 300;
            repeat (n) queue_item(FUNC_TICK, 8'($urandom), 1'($urandom));
            while (pending_q.size() != 0) @(negedge clk);
        end
    endtask

    task automatic random_regs();
        reg_image_t img;
        int top;
        top = ($urandom_range(0, 3) == 0) ? 40 : 6;
        img[REG_PULSE] = 16'($urandom);
        img[REG_PULSE][7:0] = 8'($urandom_range(0, top));
        img[REG_GAP] = 16'($urandom);
        img[REG_GAP][9:0] = 10'($urandom_range(0, top));
        img[REG_CLEAR] = 16'($urandom_range(0, top + 2));
        img[REG_WAKE] = 16'($urandom_range(0, top));
        img[REG_WAKE_FINAL] = 16'($urandom_range(0, top));
        img[REG_SETTLE] = 16'($urandom_range(0, top + 2));
        img[REG_START] = 16'($urandom_range(0, top + 2));
        program_regs(img, 1'b0);
    endtask

    // Stimulus: directed cases under several settings, then random sequences.
    initial begin
        reg_image_t img;
        int base;
        logic [7:0] b;
        logic d;

        lcd_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: idle tick, redundant power-off, data writes incl. the clear code as data.
        queue_item(FUNC_TICK, 8'h00, 1'b0);
        queue_item(FUNC_POFF, 8'h00, 1'b0);
        queue_item(FUNC_WRITE, 8'hff, 1'b1);
        run_to_idle();
        queue_item(FUNC_WRITE, CMD_CLEAR, 1'b1);
        run_to_idle();

        // A clear command stopped one tick before its clear wait would load.
        queue_item(FUNC_WRITE, CMD_CLEAR, 1'b0);
        repeat (101) queue_item(FUNC_TICK, 8'h00, 1'b0);

        // All registers zero: zero-length waits chain, zero pulse and gap act as one.
        drain();
        program_regs('0, 1'b0);
        run_to_idle();
        queue_item(FUNC_PON, 8'h00, 1'b0);
        queue_item(FUNC_WRITE, 8'h3c, 1'b1);
        queue_item(FUNC_PON, 8'h00, 1'b0);
        queue_item(FUNC_POFF, 8'h00, 1'b0);
        run_to_idle();
        queue_item(FUNC_PON, 8'h00, 1'b0);
        queue_item(FUNC_WRITE, 8'h00, 1'b0);
        run_to_idle();
        queue_item(FUNC_POFF, 8'h00, 1'b0);
        queue_item(FUNC_POFF, 8'h00, 1'b0);
        queue_item(FUNC_WRITE, 8'h5a, 1'b1);
        run_to_idle();
        queue_item(FUNC_WRITE, CMD_CLEAR, 1'b0);
        run_to_idle();

        // All registers at their largest, with stray high bits and an unused index;
        // the enable pulse is followed for most of its length.
        drain();
        program_regs('1, 1'b1);
        queue_item(FUNC_WRITE, CMD_CLEAR, 1'b0);
        repeat (250) queue_item(FUNC_TICK, 8'h00, 1'b0);

        // Moderate settings: finish the clear, then full power-on twice with a write.
        drain();
        img[REG_PULSE] = 16'd3;
        img[REG_GAP] = 16'd2;
        img[REG_CLEAR] = 16'd4;
        img[REG_WAKE] = 16'd5;
        img[REG_WAKE_FINAL] = 16'd2;
        img[REG_SETTLE] = 16'd3;
        img[REG_START] = 16'd1;
        program_regs(img, 1'b0);
        run_to_idle();
        queue_item(FUNC_PON, 8'h00, 1'b0);
        run_to_idle();
        queue_item(FUNC_WRITE, 8'hc3, 1'b1);
        run_to_idle();
        queue_item(FUNC_POFF, 8'h00, 1'b0);
        queue_item(FUNC_PON, 8'h00, 1'b0);
        run_to_idle();

        // Random sequences under a fresh random setting every twenty sequences.
        base = useful_items;
        while (useful_items - base < RANDOM_ITEMS) begin
            drain();
            random_regs();
            for (int k = 0; k < 20 && useful_items - base < RANDOM_ITEMS; k++) begin
                case ($urandom_range(0, 11))
                    0, 1, 2, 3, 4, 5: begin
                        b = 8'($urandom);
                        d = 1'($urandom);
                        if ($urandom_range(0, 3) == 0) begin
                            b = CMD_CLEAR;
                            d = 1'b0;
                        end
                        queue_item(FUNC_WRITE, b, d);
                        run_to_idle();
                    end
                    6, 7: begin
                        queue_item(FUNC_PON, 8'($urandom), 1'($urandom));
                        run_to_idle();
                    end
                    8: queue_item(FUNC_POFF, 8'($urandom), 1'($urandom));
                    9: repeat ($urandom_range(1, 4))
                        queue_item(FUNC_TICK, 8'($urandom), 1'($urandom));
                    default: begin
                        queue_item(2'($urandom), 8'($urandom), 1'($urandom));
                        run_to_idle();
                    end
                endcase
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/clnib_pkg.sv
rtl/clnib_seq.sv
rtl/clnib_outbuf.sv
rtl/char_lcd_nibble_interface_core.sv
rtl/clnib_checker.sv
test/tb_char_lcd_nibble_interface_core.sv
